>>> rtl/centroid_match_speed_estimator_defines.svh
// Assertion macros shared by the checker of centroid_match_speed_estimator.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CENTROID_MATCH_SPEED_ESTIMATOR_DEFINES_SVH
`define CENTROID_MATCH_SPEED_ESTIMATOR_DEFINES_SVH

// Implication checked in the next cycle, masked while reset is asserted.
`define CMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define CMSE_ASSERT_AFTER_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

>>> rtl/cmse_pkg.sv
// Package for centroid_match_speed_estimator: widths, register indexes, reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmse_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int SLOT_W     = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int RAM_AW     = SLOT_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;

    localparam int COORD_W    = 13;
    localparam int SIZE_W     = 12;
    localparam int CTR_W      = 14;
    localparam int ENTRY_W    = 2 * CTR_W;
    localparam int DIFF_W     = CTR_W + 1;
    localparam int SQ_W       = 28;
    localparam int D2_W       = SQ_W + 1;

    localparam int RAD_W      = 10;
    localparam int R2_W       = 2 * RAD_W;
    localparam int SCALE_W    = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int SQ_IN_W    = R2_W + FRAC_SHIFT;
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int PROD_W     = ROOT_W + SCALE_W;
    localparam int SPEED_W    = 24;
    localparam int SLOT_OUT_W = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;

    localparam logic [RAD_W-1:0]   RADIUS_RST = 10'd50;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 32'd829440;

    localparam logic OP_BOX = 1'b0;
    localparam logic OP_EOF = 1'b1;

endpackage

`default_nettype wire

>>> rtl/cmse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cmse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/cmse_sqrt.sv
// Iterative integer square root of d2 * 2^16, one root bit per cycle.
// Depends on cmse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmse_sqrt
    import cmse_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [R2_W-1:0]   d2,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int ITER_W = $clog2(ROOT_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [SQ_IN_W-1:0]  x_reg, x_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;

    assign rem_sh = {rem_reg, x_reg[SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = ITER_W'(ROOT_W);
            x_next    = {d2, {FRAC_SHIFT{1'b0}}};
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            x_next = {x_reg[SQ_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> rtl/centroid_match_speed_estimator.sv
// Centroid-match speed estimator: box input channel (s_), speed result channel (m_),
// configuration write port (cfg_). Box centres live in one RAM of two frame banks.
// A box transfer stores its centre into the current bank at once and then walks the
// previous bank. s_op = 1 marks end of frame: banks swap, s_ready stays high, no result.
// Per box with n previous centres: a pipelined scan reads all n centres and finds the last
// match, then a second walk reads them again from slot 0 up to that match and, per match,
// runs the bit-serial square root, one multiply and one output load.
// The square-root unit sets the rate; a box with no match skips the second walk.
// Results of one box come in ascending prev_slot order; m_last marks the final one.
// A box with no match gives no result. The next item is accepted only after the
// previous box's walk ends; the final result may still sit in the output register.
// If m_ready is low the output register holds and the walk waits on it.
// Reset (aresetn low, synchronous) empties both banks, selects bank 0 as current and
// loads match_radius = 50 and speed_scale = 829440; the RAM itself is not cleared.
// cfg_ready is always high; writes are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module centroid_match_speed_estimator
    import cmse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [COORD_W-1:0]    s_box_left,
    input  wire logic [COORD_W-1:0]    s_box_top,
    input  wire logic [SIZE_W-1:0]     s_box_width,
    input  wire logic [SIZE_W-1:0]     s_box_height,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [SPEED_W-1:0]    m_speed_q8,
    output logic      [SLOT_OUT_W-1:0] m_prev_slot,
    output logic                       m_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_WALK_RD   = 3'd2;
    localparam logic [2:0] ST_WALK_WAIT = 3'd3;
    localparam logic [2:0] ST_SQRT      = 3'd4;
    localparam logic [2:0] ST_MUL       = 3'd5;
    localparam logic [2:0] ST_OUT       = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [RAD_W-1:0]    radius_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic                bank_reg;
    logic [CNT_W-1:0]    prev_count_reg, cur_count_reg;
    logic [CTR_W-1:0]    cx_reg, cy_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]   walk_idx_reg, walk_idx_next;
    logic                any_hit_reg, any_hit_next;
    logic [SLOT_W-1:0]   last_hit_reg, last_hit_next;
    logic [SLOT_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                p1_vld_reg, p2_vld_reg;
    logic [SLOT_W-1:0]   p1_idx_reg, p2_idx_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                m_valid_reg;
    logic [SPEED_W-1:0]  m_speed_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic                m_last_reg;

    logic                s_xfer, box_xfer, eof_xfer, out_load, out_free;
    logic [CTR_W-1:0]    cx_in, cy_in;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                rd_issue;
    logic [SLOT_W-1:0]   rd_slot;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic signed [2*DIFF_W-1:0] dx2, dy2;
    logic [D2_W-1:0]     d2;
    logic                hit;
    logic                sq_start, sq_done;
    logic [ROOT_W-1:0]   sq_root;
    logic [PROD_W-1:0]   prod_w;
    logic [SPEED_W-1:0]  speed_sat;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign box_xfer  = s_xfer && (s_op == OP_BOX);
    assign eof_xfer  = s_xfer && (s_op == OP_EOF);
    assign out_free  = !m_valid_reg || m_ready;

    // centre with truncating halving of the size
    assign cx_in = {s_box_left[COORD_W-1], s_box_left}
                 + CTR_W'(s_box_width[SIZE_W-1:1]);
    assign cy_in = {s_box_top[COORD_W-1], s_box_top}
                 + CTR_W'(s_box_height[SIZE_W-1:1]);

    // the box's own centre goes to the current bank; walks read the other one
    assign ram_we    = box_xfer && (cur_count_reg < CNT_W'(MAX_BOXES));
    assign ram_waddr = {bank_reg, cur_count_reg[SLOT_W-1:0]};
    assign ram_raddr = {~bank_reg, rd_slot};

    cmse_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data({cy_in, cx_in}),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        rd_issue = 1'b0;
        rd_slot  = walk_idx_reg;
        if (state_reg == ST_SCAN) begin
            rd_issue = (rd_idx_reg < prev_count_reg);
            rd_slot  = rd_idx_reg[SLOT_W-1:0];
        end else if (state_reg == ST_WALK_RD) begin
            rd_issue = 1'b1;
        end
    end

    // distance pipeline: RAM data -> squares -> sum and compare
    assign dx  = DIFF_W'(signed'(cx_reg)) - DIFF_W'(signed'(ram_rdata[CTR_W-1:0]));
    assign dy  = DIFF_W'(signed'(cy_reg)) - DIFF_W'(signed'(ram_rdata[ENTRY_W-1:CTR_W]));
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign d2  = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign hit = p2_vld_reg && (d2 < D2_W'(r2_reg));

    cmse_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .d2     (d2[R2_W-1:0]),
        .done   (sq_done),
        .root   (sq_root)
    );

    assign prod_w    = sq_root * scale_reg;
    assign speed_sat = (|prod_reg[PROD_W-1:FRAC_SHIFT+SPEED_W]) ? {SPEED_W{1'b1}}
                     : prod_reg[FRAC_SHIFT+SPEED_W-1:FRAC_SHIFT];
    assign slot_ext  = {{SLOT_OUT_W{1'b0}}, hit_idx_reg};

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        walk_idx_next = walk_idx_reg;
        any_hit_next  = any_hit_reg;
        last_hit_next = last_hit_reg;
        hit_idx_next  = hit_idx_reg;
        sq_start      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (box_xfer) begin
                    rd_idx_next  = '0;
                    any_hit_next = 1'b0;
                    if (prev_count_reg != '0) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (hit) begin
                    any_hit_next  = 1'b1;
                    last_hit_next = p2_idx_reg;
                end
                if (!rd_issue && !p1_vld_reg && !p2_vld_reg) begin
                    walk_idx_next = '0;
                    state_next    = any_hit_reg ? ST_WALK_RD : ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_WAIT;
            end
            ST_WALK_WAIT: begin
                if (p2_vld_reg) begin
                    if (hit) begin
                        sq_start     = 1'b1;
                        hit_idx_next = p2_idx_reg;
                        state_next   = ST_SQRT;
                    end else begin
                        walk_idx_next = walk_idx_reg + 1'b1;
                        state_next    = ST_WALK_RD;
                    end
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (hit_idx_reg == last_hit_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        walk_idx_next = walk_idx_reg + 1'b1;
                        state_next    = ST_WALK_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            radius_reg     <= RADIUS_RST;
            scale_reg      <= SCALE_RST;
            bank_reg       <= 1'b0;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            rd_idx_reg     <= '0;
            walk_idx_reg   <= '0;
            any_hit_reg    <= 1'b0;
            last_hit_reg   <= '0;
            hit_idx_reg    <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            walk_idx_reg <= walk_idx_next;
            any_hit_reg  <= any_hit_next;
            last_hit_reg <= last_hit_next;
            hit_idx_reg  <= hit_idx_next;
            p1_vld_reg   <= rd_issue;
            p2_vld_reg   <= p1_vld_reg;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RADIUS) begin
                    radius_reg <= cfg_data[RAD_W-1:0];
                end else if (cfg_index == CFG_SCALE) begin
                    scale_reg <= cfg_data[SCALE_W-1:0];
                end
            end
            if (eof_xfer) begin
                bank_reg       <= ~bank_reg;
                prev_count_reg <= cur_count_reg;
                cur_count_reg  <= '0;
            end else if (ram_we) begin
                cur_count_reg <= cur_count_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (box_xfer) begin
            cx_reg <= cx_in;
            cy_reg <= cy_in;
            r2_reg <= R2_W'(radius_reg * radius_reg);
        end
        p1_idx_reg <= rd_slot;
        p2_idx_reg <= p1_idx_reg;
        sqx_reg    <= dx2[SQ_W-1:0];
        sqy_reg    <= dy2[SQ_W-1:0];
        prod_reg   <= prod_w;
        if (out_load) begin
            m_speed_reg <= speed_sat;
            m_slot_reg  <= slot_ext[SLOT_OUT_W-1:0];
            m_last_reg  <= (hit_idx_reg == last_hit_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_speed_q8  = m_speed_reg;
    assign m_prev_slot = m_slot_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

>>> rtl/cmse_checker.sv
// Port-level checker for centroid_match_speed_estimator, bound to the top level.
// Depends on cmse_pkg and centroid_match_speed_estimator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "centroid_match_speed_estimator_defines.svh"

module cmse_checker
    import cmse_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_op,
    input wire logic [COORD_W-1:0]    s_box_left,
    input wire logic [COORD_W-1:0]    s_box_top,
    input wire logic [SIZE_W-1:0]     s_box_width,
    input wire logic [SIZE_W-1:0]     s_box_height,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [SPEED_W-1:0]    m_speed_q8,
    input wire logic [SLOT_OUT_W-1:0] m_prev_slot,
    input wire logic                  m_last,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // no result survives reset
    `CMSE_ASSERT_AFTER_RST(a_rst_empty, !m_valid && s_ready, "output valid or busy after reset")

    // end of frame leaves the block ready in the next cycle
    `CMSE_ASSERT_NEXT(a_eof_ready, s_valid && s_ready && (s_op == OP_EOF), s_ready, "not ready after end of frame")

    // stalled result transfer holds
    `CMSE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    `CMSE_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_speed_q8) && $stable(m_prev_slot) && $stable(m_last), "result changed while stalled")

endmodule

bind centroid_match_speed_estimator cmse_checker u_cmse_checker (.*);

`default_nettype wire
